@@ hw/rtl/tcp_pkg.sv @@
// tcp_pkg: shared types, command codes and constants of the terminal cursor positioner
// no dependencies; used by the channel interfaces and every module of the block
package tcp_pkg;

   localparam int MAX_ROWS_DEFAULT = 256;
   localparam int MAX_COLS_DEFAULT = 256;

   localparam int CMD_W     = 4;
   localparam int PARAM_W   = 16;
   localparam int POS_W     = 8;
   localparam int SIZE_W    = 9;
   localparam int REP_W     = 9;
   localparam int CSR_IDX_W = 2;

   // largest screen dimension the position fields can address
   localparam int POS_LIMIT = 256;

   localparam logic [POS_W-1:0]   RESET_LAST_ROW = 8'd23;
   localparam logic [SIZE_W-1:0]  RESET_ROWS     = 9'd24;
   localparam logic [SIZE_W-1:0]  RESET_COLS     = 9'd80;
   localparam logic [PARAM_W-1:0] DSR_STATUS     = 16'd5;
   localparam logic [PARAM_W-1:0] DSR_CURSOR     = 16'd6;

   typedef enum logic [CMD_W-1:0] {
      CMD_CUP     = 4'd0,
      CMD_CUU     = 4'd1,
      CMD_CUD     = 4'd2,
      CMD_CUF     = 4'd3,
      CMD_CUB     = 4'd4,
      CMD_CNL     = 4'd5,
      CMD_CPL     = 4'd6,
      CMD_CHA     = 4'd7,
      CMD_VPA     = 4'd8,
      CMD_DECSTBM = 4'd9,
      CMD_SAVE    = 4'd10,
      CMD_RESTORE = 4'd11,
      CMD_DSR     = 4'd12
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REGION_REL  = 2'd0,
      CSR_SCREEN_ROWS = 2'd1,
      CSR_SCREEN_COLS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [PARAM_W-1:0] first_param;
      logic [PARAM_W-1:0] second_param;
   } cmd_payload_type;

   typedef struct packed {
      logic [POS_W-1:0] cursor_col;
      logic [POS_W-1:0] cursor_row;
      logic [POS_W-1:0] region_top_row;
      logic [POS_W-1:0] region_bottom_row;
      logic             report_valid;
      logic [REP_W-1:0] report_row;
      logic [REP_W-1:0] report_col;
      logic             status_ok_report;
   } result_type;

   // effective screen geometry, kept as last row and last column index
   typedef struct packed {
      logic             region_rel;
      logic [POS_W-1:0] last_row;
      logic [POS_W-1:0] last_col;
   } cfg_type;

   // size register clamped to 1..cap, returned as the last zero-based index
   function automatic logic [POS_W-1:0] last_index(logic [SIZE_W-1:0] size,
                                                    logic [SIZE_W-1:0] cap);
      logic [SIZE_W-1:0] eff;
      eff = (size == '0) ? SIZE_W'(1) : size;
      if (eff > cap) eff = cap;
      return POS_W'(eff - SIZE_W'(1));
   endfunction

endpackage

@@ hw/rtl/tcp_req_if.sv @@
// tcp_req_if: command channel of the terminal cursor positioner
// depends on tcp_pkg for field widths
interface tcp_req_if import tcp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [PARAM_W-1:0] first_param;
   logic [PARAM_W-1:0] second_param;

   modport source (output valid, cmd, first_param, second_param, input ready);
   modport sink   (input valid, cmd, first_param, second_param, output ready);
endinterface

@@ hw/rtl/tcp_rsp_if.sv @@
// tcp_rsp_if: result channel of the terminal cursor positioner
// depends on tcp_pkg for field widths
interface tcp_rsp_if import tcp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] cursor_col;
   logic [POS_W-1:0] cursor_row;
   logic [POS_W-1:0] region_top_row;
   logic [POS_W-1:0] region_bottom_row;
   logic             report_valid;
   logic [REP_W-1:0] report_row;
   logic [REP_W-1:0] report_col;
   logic             status_ok_report;

   modport source (output valid, cursor_col, cursor_row, region_top_row, region_bottom_row,
                   report_valid, report_row, report_col, status_ok_report,
                   input ready);
   modport sink   (input valid, cursor_col, cursor_row, region_top_row, region_bottom_row,
                   report_valid, report_row, report_col, status_ok_report,
                   output ready);
endinterface

@@ hw/rtl/tcp_csr.sv @@
// tcp_csr: configuration registers, stores origin mode and the clamped screen geometry
// depends on tcp_pkg
module tcp_csr import tcp_pkg::*; #(
   parameter int MAX_ROWS = MAX_ROWS_DEFAULT,
   parameter int MAX_COLS = MAX_COLS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_wdata,
   output cfg_type              cfg
);

   localparam int RowCap = (MAX_ROWS < POS_LIMIT) ? MAX_ROWS : POS_LIMIT;
   localparam int ColCap = (MAX_COLS < POS_LIMIT) ? MAX_COLS : POS_LIMIT;
   localparam logic [SIZE_W-1:0] ROW_CAP = SIZE_W'(RowCap);
   localparam logic [SIZE_W-1:0] COL_CAP = SIZE_W'(ColCap);
   localparam logic [POS_W-1:0]  RESET_ROW_IDX = last_index(RESET_ROWS, ROW_CAP);
   localparam logic [POS_W-1:0]  RESET_COL_IDX = last_index(RESET_COLS, COL_CAP);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_REGION_REL:  cfg_in.region_rel = csr_wdata[0];
            CSR_SCREEN_ROWS: cfg_in.last_row   = last_index(csr_wdata, ROW_CAP);
            CSR_SCREEN_COLS: cfg_in.last_col   = last_index(csr_wdata, COL_CAP);
            default:         cfg_in            = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.region_rel <= 1'b0;
         cfg_ff.last_row   <= RESET_ROW_IDX;
         cfg_ff.last_col   <= RESET_COL_IDX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/tcp_exec.sv @@
// tcp_exec: cursor, scroll region and saved cursor state with the per-command update logic
// depends on tcp_pkg; fed by the input stage and configuration of the top level
module tcp_exec import tcp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  cmd_payload_type item,
   input  cfg_type         cfg,
   output result_type      result
);

   logic [POS_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [POS_W-1:0] top_ff, top_in, bottom_ff, bottom_in;
   logic [POS_W-1:0] saved_col_ff, saved_col_in, saved_row_ff, saved_row_in;
   logic             saved_valid_ff, saved_valid_in;

   logic [POS_W-1:0]   bot, top, row, col, lo, hi, nt, nb, rel;
   logic [PARAM_W-1:0] p1, p1m1, p2m1;
   logic [PARAM_W:0]   abs_sum, dn_sum, fwd_sum;
   logic signed [PARAM_W+1:0] up_diff;
   logic [POS_W-1:0]   row_abs, col_abs_p1, col_abs_p2, up_row, dn_row, fwd_col, back_col;

   always_comb begin
      // fix up state left stale by a screen size change
      bot = (bottom_ff > cfg.last_row) ? cfg.last_row : bottom_ff;
      top = (top_ff > bot) ? '0 : top_ff;
      row = (row_ff > cfg.last_row) ? cfg.last_row : row_ff;
      col = (col_ff > cfg.last_col) ? cfg.last_col : col_ff;
      lo  = cfg.region_rel ? top : '0;
      hi  = cfg.region_rel ? bot : cfg.last_row;

      p1   = (item.first_param == '0) ? PARAM_W'(1) : item.first_param;
      p1m1 = p1 - PARAM_W'(1);
      p2m1 = (item.second_param == '0) ? '0 : item.second_param - PARAM_W'(1);

      // absolute row, region relative in origin mode
      abs_sum = {1'b0, p1m1} + (PARAM_W+1)'(top);
      if (cfg.region_rel)
         row_abs = (abs_sum > (PARAM_W+1)'(bot)) ? bot : abs_sum[POS_W-1:0];
      else
         row_abs = (p1m1 > PARAM_W'(cfg.last_row)) ? cfg.last_row : p1m1[POS_W-1:0];

      col_abs_p1 = (p1m1 > PARAM_W'(cfg.last_col)) ? cfg.last_col : p1m1[POS_W-1:0];
      col_abs_p2 = (p2m1 > PARAM_W'(cfg.last_col)) ? cfg.last_col : p2m1[POS_W-1:0];

      // upward moves stop at lo, which also pulls a row above the region down to top
      up_diff = $signed((PARAM_W+2)'(row) - (PARAM_W+2)'(p1));
      up_row  = (up_diff < $signed((PARAM_W+2)'(lo))) ? lo : up_diff[POS_W-1:0];

      dn_sum = (PARAM_W+1)'(row) + (PARAM_W+1)'(p1);
      dn_row = (dn_sum > (PARAM_W+1)'(hi)) ? hi : dn_sum[POS_W-1:0];

      fwd_sum  = (PARAM_W+1)'(col) + (PARAM_W+1)'(p1);
      fwd_col  = (fwd_sum > (PARAM_W+1)'(cfg.last_col)) ? cfg.last_col : fwd_sum[POS_W-1:0];
      back_col = (p1 > PARAM_W'(col)) ? '0 : col - p1[POS_W-1:0];

      nt = (p1m1 > PARAM_W'(cfg.last_row)) ? cfg.last_row : p1m1[POS_W-1:0];
      if (item.second_param == '0)
         nb = cfg.last_row;
      else
         nb = (p2m1 > PARAM_W'(cfg.last_row)) ? cfg.last_row : p2m1[POS_W-1:0];

      rel = (cfg.region_rel) ? ((row >= top) ? row - top : '0) : row;

      col_in         = col;
      row_in         = row;
      top_in         = top;
      bottom_in      = bot;
      saved_col_in   = saved_col_ff;
      saved_row_in   = saved_row_ff;
      saved_valid_in = saved_valid_ff;
      result         = '0;

      case (cmd_type'(item.cmd))
         CMD_CUP: begin
            row_in = row_abs;
            col_in = col_abs_p2;
         end
         CMD_CUU: row_in = up_row;
         CMD_CUD: row_in = dn_row;
         CMD_CUF: col_in = fwd_col;
         CMD_CUB: col_in = back_col;
         CMD_CNL: begin
            row_in = dn_row;
            col_in = '0;
         end
         CMD_CPL: begin
            row_in = up_row;
            col_in = '0;
         end
         CMD_CHA: col_in = col_abs_p1;
         CMD_VPA: row_in = row_abs;
         CMD_DECSTBM: begin
            // an empty or inverted region leaves everything alone
            if (nt < nb) begin
               top_in    = nt;
               bottom_in = nb;
               col_in    = '0;
               row_in    = cfg.region_rel ? nt : '0;
            end
         end
         CMD_SAVE: begin
            saved_col_in   = col;
            saved_row_in   = row;
            saved_valid_in = 1'b1;
         end
         CMD_RESTORE: begin
            if (saved_valid_ff) begin
               col_in = (saved_col_ff > cfg.last_col) ? cfg.last_col : saved_col_ff;
               row_in = (saved_row_ff > cfg.last_row) ? cfg.last_row : saved_row_ff;
            end
         end
         CMD_DSR: begin
            if (item.first_param == DSR_STATUS) begin
               result.status_ok_report = 1'b1;
            end else if (item.first_param == DSR_CURSOR) begin
               result.report_valid = 1'b1;
               result.report_row   = REP_W'(rel) + REP_W'(1);
               result.report_col   = REP_W'(col) + REP_W'(1);
            end
         end
         default: ;
      endcase

      result.cursor_col        = col_in;
      result.cursor_row        = row_in;
      result.region_top_row    = top_in;
      result.region_bottom_row = bottom_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff         <= '0;
         row_ff         <= '0;
         top_ff         <= '0;
         bottom_ff      <= RESET_LAST_ROW;
         saved_col_ff   <= '0;
         saved_row_ff   <= '0;
         saved_valid_ff <= 1'b0;
      end else if (advance) begin
         col_ff         <= col_in;
         row_ff         <= row_in;
         top_ff         <= top_in;
         bottom_ff      <= bottom_in;
         saved_col_ff   <= saved_col_in;
         saved_row_ff   <= saved_row_in;
         saved_valid_ff <= saved_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   // region never inverted: stale fix-up and the region command both keep top at or above bottom
   a_region_order: assert property (@(posedge clock) disable iff (reset)
      top_ff <= bottom_ff)
      else $error("scroll region top below bottom");

   // once a cursor is saved it stays saved until reset
   a_saved_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(saved_valid_ff))
      else $error("saved cursor lost");

   // the two reply kinds never come from one command
   a_reply_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(result.report_valid && result.status_ok_report))
      else $error("position report and status reply together");

   // a position report is one-based and fields are zero when there is no report
   a_report_fields: assert property (@(posedge clock) disable iff (reset)
      result.report_valid ? (result.report_row != '0 && result.report_col != '0)
                          : (result.report_row == '0 && result.report_col == '0))
      else $error("bad cursor position report fields");

   // the state only moves when a transaction is processed
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(col_ff) && $stable(row_ff) && $stable(top_ff)
                   && $stable(bottom_ff))
      else $error("cursor state changed without a transaction");
`endif

endmodule

@@ hw/rtl/terminal_cursor_positioner.sv @@
// terminal_cursor_positioner: top level, input stage, result register and channel handshakes
// depends on tcp_pkg, tcp_req_if, tcp_rsp_if, tcp_csr and tcp_exec
//
// Usage:
//  req_chan carries one decoded CSI cursor command (cmd, first_param, second_param);
//  rsp_chan returns exactly one result per command: cursor, scroll region and any
//  status or cursor position reply. Both are valid/ready channels.
//  csr_wr_en/csr_index/csr_wdata write origin mode (0), screen rows (1) and screen
//  columns (2); write them only while no command is in flight.
//  An accepted command waits in the input register and its result is registered in the
//  result register when it leaves; rsp_chan.valid rises as that register loads.
//  Throughput: one command per cycle when not stalled; the cursor state is read and
//  written in the same cycle as the result register loads, so consecutive commands
//  chain directly. Stall: while rsp_chan.ready is low the result register holds; one
//  more command is still taken into the input register, then req_chan.ready drops until
//  the result is taken.
//  Reset (synchronous, active high): cursor at (0,0), region rows 0..23, nothing
//  saved, origin mode off, 24 rows by 80 columns, both registers empty.
module terminal_cursor_positioner import tcp_pkg::*; #(
   parameter int MAX_ROWS = MAX_ROWS_DEFAULT,
   parameter int MAX_COLS = MAX_COLS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   tcp_req_if.sink              req_chan,
   tcp_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_wdata
);

   cfg_type         cfg;
   cmd_payload_type stage_ff, stage_in;
   logic            stage_valid_ff, stage_valid_in;
   result_type      out_ff, out_in, exec_result;
   logic            out_valid_ff, out_valid_in;
   logic            out_free, advance, accept;

   tcp_csr #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tcp_exec u_exec (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (stage_ff),
      .cfg     (cfg),
      .result  (exec_result)
   );

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign advance        = stage_valid_ff && out_free;
   assign req_chan.ready = !stage_valid_ff || out_free;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      stage_in              = stage_ff;
      stage_valid_in        = stage_valid_ff;
      out_in                = out_ff;
      out_valid_in          = out_valid_ff;
      if (advance) begin
         out_in       = exec_result;
         out_valid_in = 1'b1;
         stage_valid_in = 1'b0;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (accept) begin
         stage_in.cmd          = req_chan.cmd;
         stage_in.first_param  = req_chan.first_param;
         stage_in.second_param = req_chan.second_param;
         stage_valid_in        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      out_ff   <= out_in;
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.cursor_col        = out_ff.cursor_col;
   assign rsp_chan.cursor_row        = out_ff.cursor_row;
   assign rsp_chan.region_top_row    = out_ff.region_top_row;
   assign rsp_chan.region_bottom_row = out_ff.region_bottom_row;
   assign rsp_chan.report_valid      = out_ff.report_valid;
   assign rsp_chan.report_row        = out_ff.report_row;
   assign rsp_chan.report_col        = out_ff.report_col;
   assign rsp_chan.status_ok_report  = out_ff.status_ok_report;

`ifndef NO_ASSERTIONS
   // a command waiting in the input register is never dropped while the result is stalled
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !out_free |=> stage_valid_ff && $stable(stage_ff))
      else $error("queued transaction lost under stall");

   // a result only appears in the cycle after a command left the input register
   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(advance))
      else $error("result without a processed transaction");

   // no result register overwrite while it is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |-> !advance)
      else $error("pending result overwritten");
`endif

endmodule
